FILE: sv/pscl_pkg.sv
`timescale 1ns / 1ps

package pscl_pkg;

    localparam int INDEX_BITS = 10;
    localparam int WAYS       = 4;
    localparam int COUNT_BITS = 16;

    localparam int BUCKETS    = 1 << INDEX_BITS;
    localparam int ADDR_BITS  = 32;
    localparam int OUT_COUNT_BITS = 16;

    localparam logic [15:0] MAX_CONN_RESET = 16'd10;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_LIMIT   = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic [ADDR_BITS-1:0]  addr;
        logic [COUNT_BITS-1:0] count;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic                  rd_en;
        logic [INDEX_BITS-1:0] rd_index;
        logic                  wr_en;
        logic [INDEX_BITS-1:0] wr_index;
        row_t                  wr_row;
    } tbl_req_t;

    typedef enum logic {
        S_IDLE,
        S_LOOKUP
    } state_t;

endpackage

FILE: sv/pscl_req_if.sv
`timescale 1ns / 1ps

interface pscl_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] address;

    modport source (output valid, output opcode, output address, input ready);
    modport sink   (input valid, input opcode, input address, output ready);
endinterface

FILE: sv/pscl_rsp_if.sv
`timescale 1ns / 1ps

interface pscl_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] count;
    logic [1:0]  status;

    modport source (output valid, output count, output status, input ready);
    modport sink   (input valid, input count, input status, output ready);
endinterface

FILE: sv/pscl_table.sv
`timescale 1ns / 1ps

module pscl_table
    import pscl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_req_t req,
    output logic     ready,
    output row_t     rd_row
);

    // one row per bucket, all ways side by side
    row_t row_mem [BUCKETS];
    row_t rd_row_reg;

    logic                  clearing_reg;
    logic                  clearing_next;
    logic [INDEX_BITS-1:0] clear_idx_reg;
    logic [INDEX_BITS-1:0] clear_idx_next;

    always_comb
    begin
        clearing_next  = clearing_reg;
        clear_idx_next = clear_idx_reg;
        if (clearing_reg)
        begin
            clear_idx_next = clear_idx_reg + INDEX_BITS'(1);
            if (clear_idx_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_idx_reg <= '0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clear_idx_reg <= clear_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            row_mem[clear_idx_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            row_mem[req.wr_index] <= req.wr_row;
        end
        if (req.rd_en)
        begin
            rd_row_reg <= row_mem[req.rd_index];
        end
    end

    assign ready  = !clearing_reg;
    assign rd_row = rd_row_reg;

endmodule

FILE: sv/per_source_connection_limiter_unit.sv
`timescale 1ns / 1ps

// Per-source connection limiter. Each request (insert or remove of one IPv4
// source address) is handled thus: the accept edge reads the bucket row from
// the table memory, then the lookup state evaluates all ways, writes the row
// back and loads the result register once the result register is free. The
// next request is taken only once the row write-back is done, so no new
// request is accepted while one is in flight; a stalled result holds the block
// in evaluation. After reset a clearing pass zeroes all BUCKETS (1024) table
// rows, one row per cycle, with req.ready low; max_connections writes are taken
// at any time, and should be made only while no request is in flight.

module per_source_connection_limiter_unit
    import pscl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    pscl_req_if.sink          req,
    pscl_rsp_if.source        rsp,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data
);

    state_t state_reg;
    state_t state_next;

    logic [15:0]          max_conn_reg;
    logic                 op_reg;
    logic [ADDR_BITS-1:0] addr_reg;

    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    logic [OUT_COUNT_BITS-1:0] rsp_count_reg;
    logic [1:0]                rsp_status_reg;

    tbl_req_t tbl_req;
    logic     tbl_ready;
    row_t     rd_row;

    logic req_ready;
    logic leaving;

    logic [WAYS-1:0]       hit_oh;
    logic [WAYS-1:0]       free_oh;
    logic                  found;
    logic                  have_free;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [COUNT_BITS-1:0] dec_cnt;
    logic                  at_limit;
    logic [COUNT_BITS-1:0] res_cnt;
    logic [31:0]           res_cnt_wide;
    logic [1:0]            res_status;
    row_t                  new_row;

    pscl_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (tbl_req),
        .ready  (tbl_ready),
        .rd_row (rd_row)
    );

    // lowest matching way and lowest free way
    always_comb
    begin
        found     = 1'b0;
        have_free = 1'b0;
        hit_oh    = '0;
        free_oh   = '0;
        cur_cnt   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rd_row[w].valid)
            begin
                if (!found && rd_row[w].addr == addr_reg)
                begin
                    found     = 1'b1;
                    hit_oh[w] = 1'b1;
                    cur_cnt   = rd_row[w].count;
                end
            end
            else if (!have_free)
            begin
                have_free  = 1'b1;
                free_oh[w] = 1'b1;
            end
        end
    end

    always_comb
    begin
        dec_cnt    = (cur_cnt == '0) ? '0 : cur_cnt - COUNT_BITS'(1);
        at_limit   = (32'(cur_cnt) >= 32'(max_conn_reg)) || (cur_cnt == '1);
        res_cnt    = '0;
        res_status = STATUS_OK;
        new_row    = rd_row;
        if (op_reg == OP_INSERT)
        begin
            if (found)
            begin
                if (at_limit)
                begin
                    res_cnt    = cur_cnt;
                    res_status = STATUS_LIMIT;
                end
                else
                begin
                    res_cnt = cur_cnt + COUNT_BITS'(1);
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (hit_oh[w])
                        begin
                            new_row[w].count = res_cnt;
                        end
                    end
                end
            end
            else if (have_free)
            begin
                res_cnt = COUNT_BITS'(1);
                for (int w = 0; w < WAYS; w++)
                begin
                    if (free_oh[w])
                    begin
                        new_row[w].valid = 1'b1;
                        new_row[w].addr  = addr_reg;
                        new_row[w].count = COUNT_BITS'(1);
                    end
                end
            end
            else
            begin
                res_status = STATUS_FULL;
            end
        end
        else
        begin
            if (found)
            begin
                res_cnt = dec_cnt;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (hit_oh[w])
                    begin
                        if (dec_cnt == '0)
                        begin
                            new_row[w] = '0;
                        end
                        else
                        begin
                            new_row[w].count = dec_cnt;
                        end
                    end
                end
            end
            else
            begin
                res_status = STATUS_UNKNOWN;
            end
        end
        res_cnt_wide = 32'(res_cnt);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && tbl_ready)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = 1'b0;
        leaving   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = tbl_ready;
            end
            S_LOOKUP:
            begin
                leaving = !rsp_valid_reg || rsp.ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        tbl_req.rd_en    = req.valid && req_ready;
        tbl_req.rd_index = req.address[INDEX_BITS-1:0];
        tbl_req.wr_en    = leaving;
        tbl_req.wr_index = addr_reg[INDEX_BITS-1:0];
        tbl_req.wr_row   = new_row;

        rsp_valid_next = rsp_valid_reg;
        if (leaving)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            max_conn_reg  <= MAX_CONN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                max_conn_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req_ready)
        begin
            op_reg   <= req.opcode;
            addr_reg <= req.address;
        end
        if (leaving)
        begin
            rsp_count_reg  <= res_cnt_wide[OUT_COUNT_BITS-1:0];
            rsp_status_reg <= res_status;
        end
    end

    assign req.ready  = req_ready;
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.count  = rsp_count_reg;
    assign rsp.status = rsp_status_reg;

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_LOOKUP)
        else $error("accepted transfer did not start a lookup");

    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOOKUP |-> tbl_ready)
        else $error("lookup active during table clearing");

    a_result_after_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        leaving |=> rsp_valid_reg && state_reg == S_IDLE)
        else $error("write-back did not present a result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_LOOKUP)
        else $error("result appeared without a lookup");

endmodule

FILE: tb/pscl_checker.sv
`timescale 1ns / 1ps

module pscl_checker
    import pscl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pscl_req_if         req,
    pscl_rsp_if         rsp,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output int          fail_count,
    output int          outstanding,
    output int          outcome_hits [4]
);

    typedef struct packed {
        logic [OUT_COUNT_BITS-1:0] count;
        logic [1:0]                status;
    } conn_result_t;

    // shadow copy of the connection table
    logic                  slot_used  [BUCKETS][WAYS];
    logic [ADDR_BITS-1:0]  slot_addr  [BUCKETS][WAYS];
    logic [COUNT_BITS-1:0] slot_count [BUCKETS][WAYS];
    logic [15:0]           conn_limit;
    conn_result_t          result_fifo [$];

    function automatic conn_result_t account_request(input logic op,
                                                     input logic [ADDR_BITS-1:0] a);
        int                    b;
        int                    hit;
        int                    spare;
        logic [COUNT_BITS-1:0] c;
        conn_result_t          r;
        b        = int'(a[INDEX_BITS-1:0]);
        hit      = -1;
        spare    = -1;
        c        = '0;
        r.status = STATUS_OK;
        for (int w = 0; w < WAYS; w++)
        begin
            if (slot_used[b][w])
            begin
                if (hit < 0 && slot_addr[b][w] == a)
                    hit = w;
            end
            else if (spare < 0)
                spare = w;
        end
        if (op == OP_INSERT)
        begin
            if (hit >= 0)
            begin
                c = slot_count[b][hit];
                // refused at the programmed limit or at counter saturation
                if (c >= conn_limit || c == '1)
                    r.status = STATUS_LIMIT;
                else
                begin
                    c = c + 1'b1;
                    slot_count[b][hit] = c;
                end
            end
            else if (spare >= 0)
            begin
                c = COUNT_BITS'(1);
                slot_used[b][spare]  = 1'b1;
                slot_addr[b][spare]  = a;
                slot_count[b][spare] = c;
            end
            else
                r.status = STATUS_FULL;
        end
        else
        begin
            if (hit >= 0)
            begin
                c = slot_count[b][hit];
                if (c != 0)
                    c = c - 1'b1;
                if (c == 0)
                begin
                    slot_used[b][hit] = 1'b0;
                    slot_addr[b][hit] = '0;
                end
                slot_count[b][hit] = c;
            end
            else
                r.status = STATUS_UNKNOWN;
        end
        r.count = OUT_COUNT_BITS'(c);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        conn_result_t got;
        conn_result_t want;
        if (!rst_n)
        begin
            for (int b = 0; b < BUCKETS; b++)
                for (int w = 0; w < WAYS; w++)
                    slot_used[b][w] = 1'b0;
            conn_limit = MAX_CONN_RESET;
            result_fifo.delete();
            outstanding = 0;
            fail_count  = 0;
            for (int s = 0; s < 4; s++)
                outcome_hits[s] = 0;
        end
        else
        begin
            // results first: a response never belongs to a request taken on the same edge
            if (rsp.valid && rsp.ready)
            begin
                got.count  = rsp.count;
                got.status = rsp.status;
                if (result_fifo.size() == 0)
                begin
                    $error("unexpected result transfer: count %0d, status %0d",
                           got.count, got.status);
                    fail_count++;
                end
                else
                begin
                    want = result_fifo.pop_front();
                    if (got.count !== want.count)
                    begin
                        $error("count mismatch: expected %0d, got %0d", want.count, got.count);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, got.status);
                        fail_count++;
                    end
                    outcome_hits[want.status]++;
                end
            end
            if (req.valid && req.ready)
                result_fifo.push_back(account_request(req.opcode, req.address));
            if (cfg_wr_en)
                conn_limit = cfg_wr_data;
            outstanding = result_fifo.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pscl_pkg::*;

    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 285;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 150;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    pscl_req_if req_ch ();
    pscl_rsp_if rsp_ch ();

    int fail_count;
    int outstanding;
    int outcome_hits [4];

    logic no_idle      = 1'b0;
    int   hold_request = 0;
    int   n_sent       = 0;
    int   quiet        = 0;

    logic [31:0] tag_pool    [6];
    logic [31:0] bucket_pool [4];

    per_source_connection_limiter_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    pscl_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .outcome_hits (outcome_hits)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // no transfer of any kind for too long means the block is stuck
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // result side: random back-pressure, long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (no_idle)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= 26);
        end
    end

    task automatic offer(input logic op, input logic [31:0] a);
        while (!no_idle && $urandom_range(99) < 26)
        begin
            @(negedge clk);
            req_ch.valid   <= 1'b0;
            req_ch.address <= $urandom();
            @(posedge clk);
        end
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.opcode  <= op;
        req_ch.address <= a;
        do
            @(posedge clk);
        while (!req_ch.ready);
        n_sent++;
    endtask

    task automatic drain_requests();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    task automatic set_limit(input logic [15:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly a few hot buckets with more tags than ways, some fully random noise
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        if ($urandom_range(99) < 10)
            a = $urandom();
        else
            a = (tag_pool[$urandom_range(5)] << INDEX_BITS)
                | bucket_pool[$urandom_range(3)];
        return a;
    endfunction

    function automatic logic [31:0] in_bucket(input logic [31:0] tag, input int b);
        return (tag << INDEX_BITS) | b;
    endfunction

    initial
    begin
        logic [15:0] limit_plan [PHASES];
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        req_ch.valid   = 1'b0;
        req_ch.opcode  = OP_INSERT;
        req_ch.address = '0;

        for (int i = 0; i < 6; i++)
            tag_pool[i] = $urandom();
        bucket_pool[0] = 0;
        bucket_pool[1] = BUCKETS - 1;
        bucket_pool[2] = $urandom_range(BUCKETS - 2, 1);
        bucket_pool[3] = $urandom_range(BUCKETS - 2, 1);
        limit_plan = '{MAX_CONN_RESET, 16'd2, 16'hFFFF, 16'd1, 16'd0, 16'd5, MAX_CONN_RESET};
        limit_plan[5] = 16'($urandom_range(12, 3));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: unknown remove, count up and down to release
        offer(OP_REMOVE, 32'h0000_0000);
        offer(OP_INSERT, 32'h0000_0000);
        offer(OP_INSERT, 32'h0000_0000);
        offer(OP_REMOVE, 32'h0000_0000);
        offer(OP_REMOVE, 32'h0000_0000);
        offer(OP_REMOVE, 32'h0000_0000);
        offer(OP_INSERT, 32'hFFFF_FFFF);
        // fill one bucket, overflow it, free a way and reuse it
        for (int t = 1; t <= WAYS; t++)
            offer(OP_INSERT, in_bucket(t, 5));
        offer(OP_INSERT, in_bucket(WAYS + 1, 5));
        offer(OP_REMOVE, in_bucket(2, 5));
        offer(OP_INSERT, in_bucket(WAYS + 1, 5));
        offer(OP_REMOVE, in_bucket(WAYS + 2, 5));
        // limit of one: known address refused, new one admitted
        drain_requests();
        set_limit(16'd1);
        offer(OP_INSERT, 32'hFFFF_FFFF);
        offer(OP_INSERT, 32'h1234_5678);
        // zero limit: new address still admitted, then refused
        drain_requests();
        set_limit(16'd0);
        offer(OP_INSERT, 32'hFFFF_FFFF);
        offer(OP_INSERT, 32'h89AB_CDEF);
        offer(OP_INSERT, 32'h89AB_CDEF);
        drain_requests();
        set_limit(MAX_CONN_RESET);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain_requests();
                set_limit(limit_plan[p]);
            end
            no_idle = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 1 && i == 80)
                    hold_request = HOLD_CYCLES;
                if (p == 3 && i == 150)
                    drain_requests();
                offer(($urandom_range(99) < 55) ? OP_INSERT : OP_REMOVE, pick_address());
            end
        end
        no_idle = 1'b0;

        drain_requests();
        repeat (16) @(posedge clk);

        $display("Covered %0d request transfers: directed cases plus %0d limit settings,",
                 n_sent, PHASES);
        $display("limits 0, 1 and 65535 included; outcomes ok %0d, limit %0d, full %0d, unknown %0d",
                 outcome_hits[STATUS_OK], outcome_hits[STATUS_LIMIT],
                 outcome_hits[STATUS_FULL], outcome_hits[STATUS_UNKNOWN]);
        if (fail_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
